// ===== rtl/integer_to_ascii_digits_assert.svh =====
// Assertion macros for the digit converter.
`ifndef INTEGER_TO_ASCII_DIGITS_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/itad_pkg.sv =====
package itad_pkg;

  localparam int DIGIT_DEPTH = 20;
  localparam int DIGIT_IDX_W = 5;
  localparam int IN_WIDTH    = 64;

  localparam logic       KIND_DEC   = 1'b0;
  localparam logic       KIND_HEX   = 1'b1;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_F     = 7'h66;
  localparam logic [3:0] DEC_LIMIT  = 4'd9;
  localparam logic [3:0] DABBLE_MIN = 4'd5;
  localparam logic [3:0] DABBLE_ADD = 4'd3;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  typedef struct packed {
    logic [IN_WIDTH-1:0] value;
    logic                kind;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  function automatic logic [6:0] digit_to_char(input logic [3:0] d);
    logic [6:0] c;
    if (d > DEC_LIMIT) begin
      c = CHAR_A + {3'b000, d - HEX_TEN};
    end else begin
      c = CHAR_ZERO + {3'b000, d};
    end
    return c;
  endfunction

endpackage

// ===== rtl/itad_in_if.sv =====
interface itad_in_if;
  logic                          valid;
  logic                          ready;
  logic [itad_pkg::IN_WIDTH-1:0] value;
  logic                          kind;

  modport source(output valid, output value, output kind, input ready);
  modport sink(input valid, input value, input kind, output ready);
endinterface

// ===== rtl/itad_out_if.sv =====
interface itad_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       last_digit;

  modport source(output valid, output digit_char, output last_digit, input ready);
  modport sink(input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/itad_front.sv =====
module itad_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  itad_in_if.sink           in_ch,
  output itad_pkg::q_head_t head,
  input  logic              pop
);

  localparam logic [itad_pkg::IN_WIDTH-1:0] VALUE_MASK =
    itad_pkg::IN_WIDTH'((65'd1 << VALUE_WIDTH) - 65'd1);

  itad_pkg::item_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  itad_pkg::item_t item_in;

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  // mask off bits above the configured width and classify the radix
  always_comb begin
    item_in.value = in_ch.value & VALUE_MASK;
    item_in.kind  = in_ch.kind ? itad_pkg::KIND_HEX : itad_pkg::KIND_DEC;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

endmodule

// ===== rtl/itad_back.sv =====
module itad_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  itad_pkg::q_head_t head,
  output logic              pop,
  itad_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DABBLE = 2'd1;
  localparam logic [1:0] ST_SEEK   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  localparam logic [itad_pkg::DIGIT_IDX_W-1:0] TOP_IDX =
    itad_pkg::DIGIT_IDX_W'(itad_pkg::DIGIT_DEPTH - 1);

  logic [1:0]                       state;
  logic [3:0]                       digits [itad_pkg::DIGIT_DEPTH];
  logic [3:0]                       digits_next [itad_pkg::DIGIT_DEPTH];
  logic [3:0]                       adj [itad_pkg::DIGIT_DEPTH];
  logic [itad_pkg::DIGIT_DEPTH*4-1:0] hex_flat;
  logic [VALUE_WIDTH-1:0]           shreg;
  logic [CNT_W-1:0]                 cnt;
  logic [itad_pkg::DIGIT_IDX_W-1:0] idx;
  logic [3:0]                       cur_digit;
  logic                             out_valid;
  logic [6:0]                       out_char;
  logic                             out_last;
  logic                             out_free;
  logic                             emit;

  assign hex_flat  = (itad_pkg::DIGIT_DEPTH*4)'(head.item.value[VALUE_WIDTH-1:0]);
  assign cur_digit = digits[idx];
  assign out_free  = !out_valid || out_ch.ready;
  assign emit      = (state == ST_EMIT) && out_free;
  assign pop       = (state == ST_IDLE) && head.valid;

  // add 3 to every digit of 5 or more, then shift in the next value bit
  always_comb begin
    for (int i = 0; i < itad_pkg::DIGIT_DEPTH; i++) begin
      adj[i] = (digits[i] >= itad_pkg::DABBLE_MIN) ? digits[i] + itad_pkg::DABBLE_ADD
                                                    : digits[i];
    end
    digits_next[0] = {adj[0][2:0], shreg[VALUE_WIDTH-1]};
    for (int i = 1; i < itad_pkg::DIGIT_DEPTH; i++) begin
      digits_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          shreg <= head.item.value[VALUE_WIDTH-1:0];
          cnt   <= CNT_W'(VALUE_WIDTH);
          idx   <= TOP_IDX;
          for (int i = 0; i < itad_pkg::DIGIT_DEPTH; i++) begin
            digits[i] <= (head.item.kind == itad_pkg::KIND_HEX) ? hex_flat[i*4 +: 4] : 4'd0;
          end
        end
      end
      ST_DABBLE: begin
        digits <= digits_next;
        shreg  <= shreg << 1;
        cnt    <= cnt - 1'b1;
      end
      ST_SEEK: begin
        if (cur_digit == 4'd0 && idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit && idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= (head.item.kind == itad_pkg::KIND_HEX) ? ST_SEEK : ST_DABBLE;
          end
        end
        ST_DABBLE: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_SEEK;
          end
        end
        ST_SEEK: begin
          if (cur_digit != 4'd0 || idx == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit && idx == '0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= itad_pkg::digit_to_char(cur_digit);
      out_last <= (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.digit_char = out_char;
  assign out_ch.last_digit = out_last;

endmodule

// ===== rtl/integer_to_ascii_digits.sv =====
// channel   direction  transaction payload
// in_ch     sink       value[63:0], kind (0 decimal, 1 hex)
// out_ch    source     digit_char[6:0], last_digit
//
// Decimal: a load step, then double dabble over VALUE_WIDTH bits at one bit per cycle,
// then a seek for the leading digit of 20, then one digit per cycle while out_ch accepts.
// Hex: a load step, the same seek, then one digit per cycle while out_ch accepts.
// A 2-entry queue holds accepted transactions while the converter is busy.
// rst is synchronous; a stalled out_ch holds the current digit and pauses emission.
`include "integer_to_ascii_digits_assert.svh"

module integer_to_ascii_digits #(
  parameter int VALUE_WIDTH = 64
) (
  input logic        clk,
  input logic        rst,
  itad_in_if.sink    in_ch,
  itad_out_if.source out_ch
);

  itad_pkg::q_head_t head;
  logic              pop;
  logic              char_ok;

  itad_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  itad_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  assign char_ok =
    (out_ch.digit_char >= itad_pkg::CHAR_ZERO && out_ch.digit_char <= itad_pkg::CHAR_NINE) ||
    (out_ch.digit_char >= itad_pkg::CHAR_A && out_ch.digit_char <= itad_pkg::CHAR_F);

  `ASSERT_IMPLIES(a_pop_has_item, clk, rst, pop, head.valid)
  `ASSERT_NEXT(a_push_keeps_head, clk, rst, in_ch.valid && in_ch.ready && !pop, head.valid)
  `ASSERT_IMPLIES(a_char_is_digit, clk, rst, out_ch.valid, char_ok)

endmodule
